>>> sv/pf_pkg.sv
package pf_pkg;

    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_KEY      = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_TEXT     = 3'd3;
    localparam logic [2:0] OP_END      = 3'd4;

    localparam int unsigned SQ_SIDE  = 5;
    localparam int unsigned SQ_CELLS = 25;
    localparam int unsigned LETTERS  = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LETTER_LAST = 5'd25;
    localparam logic [4:0] CELLS_FULL  = 5'd25;

    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_Z = 8'h5A;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_Z = 8'h7A;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_in;
        logic       decipher;
    } in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } out_t;

    // table port requests from the sequencer
    typedef struct packed {
        logic       we;
        logic [4:0] wr_cell;
        logic [4:0] wr_letter;
        logic       pos_re;
        logic [4:0] pos_raddr;
        logic       sq_re;
        logic [4:0] sq_raddr;
    } tbl_req_t;

endpackage

>>> sv/pf_tables.sv
module pf_tables (
    input  logic              aclk,
    input  pf_pkg::tbl_req_t  req,
    output logic [4:0]        pos_rd_data,
    output logic [4:0]        sq_rd_data
);

    logic [4:0] square_mem [0:pf_pkg::SQ_CELLS-1];
    logic [4:0] pos_mem    [0:pf_pkg::LETTERS-1];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            square_mem[req.wr_cell] <= req.wr_letter;
            pos_mem[req.wr_letter]  <= req.wr_cell;
        end
        if (req.pos_re) begin
            pos_rd_data <= pos_mem[req.pos_raddr];
        end
        if (req.sq_re) begin
            sq_rd_data <= square_mem[req.sq_raddr];
        end
    end

endmodule

>>> sv/pf_pair_xform.sv
module pf_pair_xform (
    input  logic [4:0] pa,
    input  logic [4:0] pb,
    input  logic       decipher,
    output logic [4:0] na,
    output logic [4:0] nb
);

    function automatic logic [4:0] wrap_cell(input logic [4:0] p);
        wrap_cell = (p >= pf_pkg::CELLS_FULL) ? p - pf_pkg::CELLS_FULL : p;
    endfunction

    function automatic logic [2:0] row_of(input logic [4:0] p);
        priority if (p >= 5'd20) row_of = 3'd4;
        else if (p >= 5'd15)     row_of = 3'd3;
        else if (p >= 5'd10)     row_of = 3'd2;
        else if (p >= 5'd5)      row_of = 3'd1;
        else                     row_of = 3'd0;
    endfunction

    function automatic logic [4:0] times5(input logic [2:0] r);
        times5 = {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
        if (back) begin
            step5 = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end else begin
            step5 = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
    endfunction

    logic [4:0] pa_w, pb_w;
    logic [2:0] ra, rb, ca, cb;
    logic [4:0] ca_w, cb_w;

    always_comb begin
        pa_w = wrap_cell(pa);
        pb_w = wrap_cell(pb);
        ra   = row_of(pa_w);
        rb   = row_of(pb_w);
        ca_w = pa_w - times5(ra);
        cb_w = pb_w - times5(rb);
        ca   = ca_w[2:0];
        cb   = cb_w[2:0];
        if (ra == rb) begin
            na = times5(ra) + {2'b00, step5(ca, decipher)};
            nb = times5(rb) + {2'b00, step5(cb, decipher)};
        end else if (ca == cb) begin
            na = times5(step5(ra, decipher)) + {2'b00, ca};
            nb = times5(step5(rb, decipher)) + {2'b00, cb};
        end else begin
            na = times5(ra) + {2'b00, cb};
            nb = times5(rb) + {2'b00, ca};
        end
    end

endmodule

>>> sv/playfair_digraph_cipher_core.sv
// Playfair 5x5 cipher core. Requests carry an opcode: clear key, key letter,
// complete square, text character or end of text. Clear, key letter, a
// non-letter and an unpaired text letter finish in the idle state. Complete
// square walks all 26 letters in a fill state. A text character that closes
// a pair, or end of text with a pending letter, steps through the request
// cycle, two position-table reads, the pair rule, two square reads and two
// output letters, each waiting while the result side stalls, all through
// one read port per table. The block takes no request while this runs; the
// output register lets a new request in while the last letter still waits to
// be taken. Text before the square is complete reads undefined table contents.
module playfair_digraph_cipher_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pf_pkg::in_t   s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pf_pkg::out_t  m_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_POSA, S_POSB, S_XF, S_SQA, S_SQB, S_OUTA, S_OUTB
    } state_t;

    state_t       state_reg, state_next;
    logic [25:0]  used_reg, used_next;
    logic [4:0]   fill_reg, fill_next;
    logic [4:0]   pend_letter_reg, pend_letter_next;
    logic         pend_lower_reg, pend_lower_next;
    logic         pend_valid_reg, pend_valid_next;
    logic [4:0]   a_letter_reg, a_letter_next;
    logic         a_lower_reg, a_lower_next;
    logic [4:0]   b_letter_reg, b_letter_next;
    logic         b_lower_reg, b_lower_next;
    logic         dec_reg, dec_next;
    logic         final_reg, final_next;
    logic [4:0]   k_reg, k_next;
    logic [4:0]   pa_reg, pa_next;
    logic [4:0]   na_reg, na_next;
    logic [4:0]   nb_reg, nb_next;
    logic [4:0]   a_code_reg, a_code_next;
    logic         m_valid_reg, m_valid_next;
    pf_pkg::out_t m_data_reg, m_data_next;

    pf_pkg::tbl_req_t req;
    logic [4:0]   pos_rd_data, sq_rd_data;
    logic [4:0]   xf_na, xf_nb;

    logic         is_letter, is_lower;
    logic [7:0]   code_wide;
    logic [4:0]   code;
    logic         accept, slot_free;

    pf_tables u_tables (
        .aclk        (aclk),
        .req         (req),
        .pos_rd_data (pos_rd_data),
        .sq_rd_data  (sq_rd_data)
    );

    pf_pair_xform u_xform (
        .pa       (pa_reg),
        .pb       (pos_rd_data),
        .decipher (dec_reg),
        .na       (xf_na),
        .nb       (xf_nb)
    );

    function automatic logic [7:0] letter_char(input logic [4:0] c, input logic low);
        logic [7:0] ch;
        ch = pf_pkg::CHAR_UP_A + {3'b000, c};
        letter_char = ch | {2'b00, low, 5'b00000};
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        is_lower  = 1'b0;
        is_letter = 1'b0;
        code_wide = 8'd0;
        if (s_data.char_in >= pf_pkg::CHAR_UP_A && s_data.char_in <= pf_pkg::CHAR_UP_Z) begin
            is_letter = 1'b1;
            code_wide = s_data.char_in - pf_pkg::CHAR_UP_A;
        end else if (s_data.char_in >= pf_pkg::CHAR_LO_A &&
                     s_data.char_in <= pf_pkg::CHAR_LO_Z) begin
            is_letter = 1'b1;
            is_lower  = 1'b1;
            code_wide = s_data.char_in - pf_pkg::CHAR_LO_A;
        end
        code = (code_wide[4:0] == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : code_wide[4:0];
    end

    always_comb begin
        state_next       = state_reg;
        used_next        = used_reg;
        fill_next        = fill_reg;
        pend_letter_next = pend_letter_reg;
        pend_lower_next  = pend_lower_reg;
        pend_valid_next  = pend_valid_reg;
        a_letter_next    = a_letter_reg;
        a_lower_next     = a_lower_reg;
        b_letter_next    = b_letter_reg;
        b_lower_next     = b_lower_reg;
        dec_next         = dec_reg;
        final_next       = final_reg;
        k_next           = k_reg;
        pa_next          = pa_reg;
        na_next          = na_reg;
        nb_next          = nb_reg;
        a_code_next      = a_code_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        req              = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_data.opcode)
                        pf_pkg::OP_CLEAR: begin
                            used_next        = 26'd1 << pf_pkg::LETTER_J;
                            fill_next        = 5'd0;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = 5'd0;
                            pend_lower_next  = 1'b0;
                        end
                        pf_pkg::OP_KEY: begin
                            if (is_letter && !used_reg[code] &&
                                fill_reg < pf_pkg::CELLS_FULL) begin
                                req.we          = 1'b1;
                                req.wr_cell     = fill_reg;
                                req.wr_letter   = code;
                                fill_next       = fill_reg + 5'd1;
                                used_next[code] = 1'b1;
                            end
                        end
                        pf_pkg::OP_COMPLETE: begin
                            k_next     = 5'd0;
                            state_next = S_FILL;
                        end
                        pf_pkg::OP_TEXT: begin
                            if (is_letter) begin
                                if (!pend_valid_reg) begin
                                    pend_letter_next = code;
                                    pend_lower_next  = is_lower;
                                    pend_valid_next  = 1'b1;
                                end else begin
                                    a_letter_next = pend_letter_reg;
                                    a_lower_next  = pend_lower_reg;
                                    dec_next      = s_data.decipher;
                                    final_next    = 1'b0;
                                    state_next    = S_POSA;
                                    if (!s_data.decipher && code == pend_letter_reg) begin
                                        b_letter_next    = pf_pkg::LETTER_X;
                                        b_lower_next     = 1'b0;
                                        pend_letter_next = code;
                                        pend_lower_next  = is_lower;
                                    end else begin
                                        b_letter_next   = code;
                                        b_lower_next    = is_lower;
                                        pend_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        pf_pkg::OP_END: begin
                            if (pend_valid_reg) begin
                                a_letter_next   = pend_letter_reg;
                                a_lower_next    = pend_lower_reg;
                                b_letter_next   = pf_pkg::LETTER_X;
                                b_lower_next    = 1'b0;
                                dec_next        = s_data.decipher;
                                final_next      = 1'b1;
                                pend_valid_next = 1'b0;
                                state_next      = S_POSA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (!used_reg[k_reg] && fill_reg < pf_pkg::CELLS_FULL) begin
                    req.we           = 1'b1;
                    req.wr_cell      = fill_reg;
                    req.wr_letter    = k_reg;
                    fill_next        = fill_reg + 5'd1;
                    used_next[k_reg] = 1'b1;
                end
                k_next = k_reg + 5'd1;
                if (k_reg == pf_pkg::LETTER_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_POSA: begin
                req.pos_re    = 1'b1;
                req.pos_raddr = a_letter_reg;
                state_next    = S_POSB;
            end
            S_POSB: begin
                req.pos_re    = 1'b1;
                req.pos_raddr = b_letter_reg;
                pa_next       = pos_rd_data;
                state_next    = S_XF;
            end
            S_XF: begin
                na_next    = xf_na;
                nb_next    = xf_nb;
                state_next = S_SQA;
            end
            S_SQA: begin
                req.sq_re    = 1'b1;
                req.sq_raddr = na_reg;
                state_next   = S_SQB;
            end
            S_SQB: begin
                req.sq_re    = 1'b1;
                req.sq_raddr = nb_reg;
                a_code_next  = sq_rd_data;
                state_next   = S_OUTA;
            end
            S_OUTA: begin
                if (slot_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = letter_char(a_code_reg, a_lower_reg);
                    m_data_next.last     = 1'b0;
                    state_next           = S_OUTB;
                end
            end
            S_OUTB: begin
                if (slot_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = letter_char(sq_rd_data, b_lower_reg);
                    m_data_next.last     = final_reg;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            used_reg        <= 26'd1 << pf_pkg::LETTER_J;
            fill_reg        <= 5'd0;
            pend_letter_reg <= 5'd0;
            pend_lower_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            k_reg           <= 5'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            fill_reg        <= fill_next;
            pend_letter_reg <= pend_letter_next;
            pend_lower_reg  <= pend_lower_next;
            pend_valid_reg  <= pend_valid_next;
            k_reg           <= k_next;
            m_valid_reg     <= m_valid_next;
        end
        a_letter_reg <= a_letter_next;
        a_lower_reg  <= a_lower_next;
        b_letter_reg <= b_letter_next;
        b_lower_reg  <= b_lower_next;
        dec_reg      <= dec_next;
        final_reg    <= final_next;
        pa_reg       <= pa_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        a_code_reg   <= a_code_next;
        m_data_reg   <= m_data_next;
    end

endmodule

>>> sim/tb_playfair_digraph_cipher_core.sv
module tb_playfair_digraph_cipher_core;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int ITEM_TARGET  = 1450;
    localparam int SHIFT_FWD    = 1;
    localparam int SHIFT_BACK   = pf_pkg::SQ_SIDE - 1;
    localparam bit ENC          = 1'b0;
    localparam bit DEC          = 1'b1;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct {
        pf_pkg::in_t req;
        bit          drain;
    } queued_req_t;

    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    pf_pkg::in_t  s_data  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    pf_pkg::out_t m_data;

    // predictor state
    logic [4:0]  grid [pf_pkg::SQ_CELLS];
    logic [4:0]  where_is [pf_pkg::LETTERS];
    logic [25:0] taken    = 26'd1 << pf_pkg::LETTER_J;
    int          fill     = 0;
    logic [4:0]  held     = '0;
    bit          held_low = 1'b0;
    bit          held_ok  = 1'b0;

    queued_req_t  request_q[$];
    pf_pkg::out_t cipher_letters_q[$];
    queued_req_t  next_req;
    pf_pkg::out_t want;
    bit           drain_next = 1'b0;

    int accepted_cnt   = 0;
    int letters_seen   = 0;
    int last_seen      = 0;
    int squares_built  = 0;
    int errors         = 0;
    int cycle_cnt      = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int rx_mode        = 0;
    int rx_left        = 0;

    playfair_digraph_cipher_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic int fold_char(input logic [7:0] ch, output bit lo);
        int c;
        c  = -1;
        lo = 1'b0;
        if (ch >= pf_pkg::CHAR_UP_A && ch <= pf_pkg::CHAR_UP_Z) begin
            c = int'(ch - pf_pkg::CHAR_UP_A);
        end else if (ch >= pf_pkg::CHAR_LO_A && ch <= pf_pkg::CHAR_LO_Z) begin
            c  = int'(ch - pf_pkg::CHAR_LO_A);
            lo = 1'b1;
        end
        if (c == int'(pf_pkg::LETTER_J)) begin
            c = int'(pf_pkg::LETTER_I);
        end
        return c;
    endfunction

    function automatic logic [7:0] letter_of(input logic [4:0] code, input bit lo);
        return (lo ? pf_pkg::CHAR_LO_A : pf_pkg::CHAR_UP_A) + {3'b000, code};
    endfunction

    function automatic logic [7:0] random_letter(input int code);
        return ($urandom_range(0, 1) ? pf_pkg::CHAR_LO_A : pf_pkg::CHAR_UP_A) + 8'(code);
    endfunction

    function automatic void place_in_square(input int code);
        if (fill < pf_pkg::SQ_CELLS) begin
            grid[fill]     = 5'(code);
            where_is[code] = 5'(fill);
            fill++;
            taken[code]    = 1'b1;
        end
    endfunction

    function automatic void transform_pair(input logic [4:0] a, input bit a_lo,
                                           input logic [4:0] b, input bit b_lo,
                                           input bit dec, input bit fin);
        int           sh, pa, pb, ra, ca, rb, cb, na, nb;
        pf_pkg::out_t r;
        sh = dec ? SHIFT_BACK : SHIFT_FWD;
        pa = int'(where_is[a]) % pf_pkg::SQ_CELLS;
        pb = int'(where_is[b]) % pf_pkg::SQ_CELLS;
        ra = pa / pf_pkg::SQ_SIDE;
        ca = pa % pf_pkg::SQ_SIDE;
        rb = pb / pf_pkg::SQ_SIDE;
        cb = pb % pf_pkg::SQ_SIDE;
        if (ra == rb) begin
            na = ra * pf_pkg::SQ_SIDE + (ca + sh) % pf_pkg::SQ_SIDE;
            nb = rb * pf_pkg::SQ_SIDE + (cb + sh) % pf_pkg::SQ_SIDE;
        end else if (ca == cb) begin
            na = ((ra + sh) % pf_pkg::SQ_SIDE) * pf_pkg::SQ_SIDE + ca;
            nb = ((rb + sh) % pf_pkg::SQ_SIDE) * pf_pkg::SQ_SIDE + cb;
        end else begin
            na = ra * pf_pkg::SQ_SIDE + cb;
            nb = rb * pf_pkg::SQ_SIDE + ca;
        end
        r.char_out = letter_of(grid[na], a_lo);
        r.last     = 1'b0;
        cipher_letters_q.insert(cipher_letters_q.size(), r);
        r.char_out = letter_of(grid[nb], b_lo);
        r.last     = fin;
        cipher_letters_q.insert(cipher_letters_q.size(), r);
    endfunction

    function automatic void advance_cipher(input pf_pkg::in_t r);
        int c;
        int k;
        bit lo;
        c = fold_char(r.char_in, lo);
        case (r.opcode)
            pf_pkg::OP_CLEAR: begin
                taken    = 26'd1 << pf_pkg::LETTER_J;
                fill     = 0;
                held     = '0;
                held_low = 1'b0;
                held_ok  = 1'b0;
            end
            pf_pkg::OP_KEY: begin
                if (c >= 0 && !taken[c]) begin
                    place_in_square(c);
                end
            end
            pf_pkg::OP_COMPLETE: begin
                squares_built++;
                for (k = 0; k < pf_pkg::LETTERS; k++) begin
                    if (!taken[k]) begin
                        place_in_square(k);
                    end
                end
            end
            pf_pkg::OP_TEXT: begin
                if (c >= 0) begin
                    if (!held_ok) begin
                        held     = 5'(c);
                        held_low = lo;
                        held_ok  = 1'b1;
                    end else if (!r.decipher && 5'(c) == held) begin
                        // doubled letter: split with X, second letter stays pending
                        transform_pair(held, held_low, pf_pkg::LETTER_X, 1'b0, ENC, 1'b0);
                        held     = 5'(c);
                        held_low = lo;
                    end else begin
                        transform_pair(held, held_low, 5'(c), lo, r.decipher, 1'b0);
                        held_ok = 1'b0;
                    end
                end
            end
            pf_pkg::OP_END: begin
                if (held_ok) begin
                    transform_pair(held, held_low, pf_pkg::LETTER_X, 1'b0, r.decipher, 1'b1);
                    held_ok = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic push_req(input logic [2:0] op, input logic [7:0] ch, input logic dec);
        queued_req_t q;
        q.req.opcode   = op;
        q.req.char_in  = ch;
        q.req.decipher = dec;
        q.drain        = drain_next;
        drain_next     = 1'b0;
        request_q.insert(request_q.size(), q);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                advance_cipher(s_data);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].drain && cipher_letters_q.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    next_req = request_q.pop_front();
                    s_data  <= next_req.req;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!long_hold_done && accepted_cnt >= 300) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(10, 150);
                end else begin
                    rx_left--;
                end
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cipher_letters_q.size() == 0) begin
                $display("%0t: unexpected letter char_out=%h last=%b",
                         $time, m_data.char_out, m_data.last);
                errors++;
            end else begin
                want = cipher_letters_q.pop_front();
                letters_seen++;
                if (m_data.last) begin
                    last_seen++;
                end
                if (m_data.char_out !== want.char_out) begin
                    $display("%0t: char_out mismatch, expected %h got %h",
                             $time, want.char_out, m_data.char_out);
                    errors++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b got %b",
                             $time, want.last, m_data.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d letters outstanding",
                     cycle_cnt, cipher_letters_q.size());
            $display("** playfair_digraph_cipher_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int         useful;
        int         phase;
        int         n;
        int         k;
        int         prev_code;
        int         code;
        int         sel;
        bit         dec;
        bit         mixed;
        logic [7:0] ch;

        // key with case folding, J, duplicate and boundary non-letters
        push_req(pf_pkg::OP_KEY, "P", ENC);
        push_req(pf_pkg::OP_KEY, "l", DEC);
        push_req(pf_pkg::OP_KEY, "a", ENC);
        push_req(pf_pkg::OP_KEY, "j", DEC);
        push_req(pf_pkg::OP_KEY, "p", ENC);
        push_req(pf_pkg::OP_KEY, 8'h00, ENC);
        push_req(pf_pkg::OP_KEY, 8'hFF, DEC);
        push_req(pf_pkg::OP_KEY, "@", ENC);
        push_req(pf_pkg::OP_KEY, "{", ENC);
        push_req(pf_pkg::OP_COMPLETE, "Z", DEC);
        push_req(pf_pkg::OP_KEY, "Q", ENC);      // square already full
        push_req(pf_pkg::OP_TEXT, "H", ENC);
        push_req(pf_pkg::OP_TEXT, "e", ENC);
        push_req(pf_pkg::OP_TEXT, "l", ENC);
        push_req(pf_pkg::OP_TEXT, "L", ENC);     // doubled letter
        push_req(pf_pkg::OP_TEXT, "o", ENC);
        push_req(pf_pkg::OP_TEXT, "j", DEC);
        push_req(pf_pkg::OP_TEXT, "i", DEC);     // equal pair kept when deciphering
        push_req(pf_pkg::OP_TEXT, "Z", ENC);
        push_req(pf_pkg::OP_END, 8'h00, DEC);    // odd letter padded
        push_req(pf_pkg::OP_END, 8'hFF, ENC);    // nothing pending
        push_req(OP_UNUSED_FIRST, "a", ENC);
        push_req(OP_UNUSED_FIRST + 3'd1, "b", DEC);
        push_req(OP_UNUSED_LAST, 8'hFF, DEC);
        push_req(pf_pkg::OP_TEXT, "[", ENC);

        useful = 20;
        phase  = 0;
        while (useful < ITEM_TARGET) begin
            phase++;
            drain_next = (phase == 5) || ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0) begin
                push_req(pf_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
                n = $urandom_range(0, 14);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        ch = 8'($urandom_range(0, 255));
                    end else begin
                        ch = random_letter($urandom_range(0, pf_pkg::LETTERS - 1));
                    end
                    push_req(pf_pkg::OP_KEY, ch, 1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 5) != 0) begin
                    push_req(pf_pkg::OP_COMPLETE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 5) == 0) begin
                    push_req(pf_pkg::OP_KEY,
                             random_letter($urandom_range(0, pf_pkg::LETTERS - 1)),
                             1'($urandom_range(0, 1)));
                end
                useful += n + 2;
            end
            dec       = 1'($urandom_range(0, 1));
            mixed     = ($urandom_range(0, 7) == 0);
            n         = $urandom_range(1, 30);
            prev_code = $urandom_range(0, pf_pkg::LETTERS - 1);
            for (k = 0; k < n; k++) begin
                sel = $urandom_range(0, 15);
                if (sel == 0) begin
                    ch = 8'($urandom_range(0, 255));
                end else begin
                    code      = (sel < 4) ? prev_code
                                          : $urandom_range(0, pf_pkg::LETTERS - 1);
                    ch        = random_letter(code);
                    prev_code = code;
                end
                push_req(pf_pkg::OP_TEXT, ch, mixed ? 1'($urandom_range(0, 1)) : dec);
            end
            if ($urandom_range(0, 4) != 0) begin
                push_req(pf_pkg::OP_END, 8'($urandom_range(0, 255)),
                         mixed ? 1'($urandom_range(0, 1)) : dec);
            end
            if ($urandom_range(0, 15) == 0) begin
                push_req(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            useful += n + 1;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_valid) @(posedge aclk);
        while (cipher_letters_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests, %0d square completions, %0d cipher letters",
                 accepted_cnt, squares_built, letters_seen);
        $display("%0d end-of-text pads seen, %0d mismatches", last_seen, errors);
        if (errors == 0) begin
            $display("** playfair_digraph_cipher_core: PASSED **");
        end else begin
            $display("** playfair_digraph_cipher_core: FAILED **");
        end
        $finish;
    end

endmodule
